@@ design/f32rmr_pkg.sv @@
package f32rmr_pkg;

  localparam int unsigned LANES = 16;
  localparam logic [31:0] F32_EXP  = 32'h7f800000;
  localparam logic [31:0] F32_MANT = 32'h007fffff;
  localparam logic [31:0] F32_QNAN = 32'h7fc00000;

  localparam logic [7:0] REG_ROW_COLUMNS     = 8'd0;
  localparam logic [7:0] REG_ROW_REPETITIONS = 8'd1;

  localparam logic [3:0] MERGE_ORDER [LANES] = '{
    4'd12, 4'd4, 4'd8, 4'd0, 4'd14, 4'd6, 4'd10, 4'd2,
    4'd13, 4'd5, 4'd9, 4'd1, 4'd15, 4'd7, 4'd11, 4'd3
  };

  typedef enum logic [1:0] {
    ST_RUN,
    ST_MERGE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       merge;
    logic [3:0] merge_idx;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic ends;
    logic merge_go;
    logic out_free;
  } sts_t;

  function automatic logic is_nan32(input logic [31:0] b);
    return ((b & F32_EXP) == F32_EXP) && ((b & F32_MANT) != 32'd0);
  endfunction

  // IEEE a >= b on non-NaN patterns, signed zeros equal
  function automatic logic ge32(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    ka = a[31] ? ~a : (a | 32'h80000000);
    kb = b[31] ? ~b : (b | 32'h80000000);
    if (((a | b) & 32'h7fffffff) == 32'd0) return 1'b1;
    return ka >= kb;
  endfunction

  function automatic logic [63:0] widen(input logic [31:0] b);
    logic [7:0]  e;
    logic [22:0] m;
    logic [4:0]  p;
    logic [63:0] sh;
    e  = b[30:23];
    m  = b[22:0];
    p  = 5'd0;
    for (int j = 0; j < 23; j++) begin
      if (m[j]) p = 5'(j);
    end
    sh = 64'(m) << (6'd52 - 6'(p));
    if (e == 8'hff) begin
      if (m == 23'd0) return {b[31], 11'h7ff, 52'd0};
      return {b[31], 11'h7ff, 1'b1, m[21:0], 29'd0};
    end
    if (e == 8'd0) begin
      if (m == 23'd0) return {b[31], 63'd0};
      return {b[31], 11'(p) + 11'd874, sh[51:0]};
    end
    return {b[31], 11'(e) + 11'd896, m, 29'd0};
  endfunction

endpackage

@@ design/f32rmr_ctrl.sv @@
module f32rmr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  f32rmr_pkg::sts_t   sts,
  output f32rmr_pkg::cmd_t   cmd
);

  f32rmr_pkg::state_t state, state_next;
  logic [3:0] k;
  logic       end_pending;

  always_comb begin
    state_next = state;
    case (state)
      f32rmr_pkg::ST_RUN: begin
        if (in_valid) begin
          if (sts.merge_go) state_next = f32rmr_pkg::ST_MERGE;
          else if (sts.ends) state_next = f32rmr_pkg::ST_EMIT;
        end
      end
      f32rmr_pkg::ST_MERGE: begin
        if (k == 4'd15) begin
          state_next = end_pending ? f32rmr_pkg::ST_EMIT : f32rmr_pkg::ST_RUN;
        end
      end
      f32rmr_pkg::ST_EMIT: begin
        if (sts.out_free) state_next = f32rmr_pkg::ST_RUN;
      end
      default: state_next = f32rmr_pkg::ST_RUN;
    endcase
  end

  always_comb begin
    in_ready      = (state == f32rmr_pkg::ST_RUN);
    cmd.accept    = (state == f32rmr_pkg::ST_RUN) && in_valid;
    cmd.merge     = (state == f32rmr_pkg::ST_MERGE);
    cmd.merge_idx = k;
    cmd.emit      = (state == f32rmr_pkg::ST_EMIT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= f32rmr_pkg::ST_RUN;
      k           <= 4'd0;
      end_pending <= 1'b0;
    end else begin
      state <= state_next;
      if (state == f32rmr_pkg::ST_MERGE) k <= k + 4'd1;
      else k <= 4'd0;
      if (cmd.accept && sts.merge_go) end_pending <= sts.ends;
    end
  end

endmodule

@@ design/f32rmr_dpath.sv @@
module f32rmr_dpath #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  f32rmr_pkg::cmd_t cmd,
  output f32rmr_pkg::sts_t sts,
  input  logic [31:0]      sample_bits,
  input  logic             cfg_valid,
  input  logic [7:0]       cfg_index,
  input  logic [15:0]      cfg_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [63:0]      maximum_bits,
  output logic             result_is_nan
);

  logic [15:0] row_columns;
  logic [15:0] row_repetitions;
  logic [31:0] total_m1;
  logic [31:0] blocks;
  logic [COUNT_WIDTH-1:0] element_counter;
  logic [31:0] cnt_ext;
  logic [31:0] lane_values [f32rmr_pkg::LANES];
  logic [31:0] running_maximum;
  logic [31:0] held_nan;
  logic        nan_seen;
  logic [3:0]  lane_sel;
  logic [3:0]  rd_idx;
  logic [31:0] rd_val;
  logic        x_nan;
  logic [15:0] eff_c;
  logic [15:0] eff_r;
  logic [31:0] res;

  assign cnt_ext = 32'(element_counter);
  assign blocks  = {total_m1[31:4], 4'd0};
  assign x_nan   = f32rmr_pkg::is_nan32(sample_bits);
  assign lane_sel = cnt_ext[3:0] - 4'd1;
  assign rd_idx  = cmd.merge ? f32rmr_pkg::MERGE_ORDER[cmd.merge_idx] : lane_sel;
  assign rd_val  = lane_values[rd_idx];
  assign res     = nan_seen ? held_nan : running_maximum;

  assign sts.ends     = (cnt_ext >= total_m1);
  assign sts.merge_go = (cnt_ext == blocks) && (cnt_ext != 32'd0) && !nan_seen && !x_nan;
  assign sts.out_free = !out_valid || out_ready;

  always_comb begin
    eff_c = (row_columns == 16'd0) ? 16'd1 : row_columns;
    eff_r = (row_repetitions == 16'd0) ? 16'd1 : row_repetitions;
    if (cfg_index == f32rmr_pkg::REG_ROW_COLUMNS) begin
      eff_c = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
    end else if (cfg_index == f32rmr_pkg::REG_ROW_REPETITIONS) begin
      eff_r = (cfg_data == 16'd0) ? 16'd1 : cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_columns     <= 16'd1;
      row_repetitions <= 16'd1;
      total_m1        <= 32'd0;
      element_counter <= '0;
      running_maximum <= 32'd0;
      held_nan        <= 32'd0;
      nan_seen        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == f32rmr_pkg::REG_ROW_COLUMNS) row_columns <= cfg_data;
        if (cfg_index == f32rmr_pkg::REG_ROW_REPETITIONS) row_repetitions <= cfg_data;
        total_m1 <= 32'(eff_c * eff_r) - 32'd1;
      end
      if (cmd.accept) begin
        if (sts.ends) element_counter <= '0;
        else element_counter <= element_counter + 1'b1;
        if (cnt_ext == 32'd0) begin
          running_maximum <= sample_bits;
          nan_seen        <= x_nan;
          if (total_m1 == 32'd0) held_nan <= sample_bits;
          else held_nan <= x_nan ? f32rmr_pkg::F32_QNAN : 32'd0;
        end else if (!nan_seen) begin
          if (x_nan) begin
            nan_seen <= 1'b1;
            held_nan <= (cnt_ext <= blocks) ? f32rmr_pkg::F32_QNAN : sample_bits;
          end else if (cnt_ext > blocks && f32rmr_pkg::ge32(sample_bits, running_maximum)) begin
            running_maximum <= sample_bits;
          end
        end
      end
      if (cmd.merge) begin
        if (cmd.merge_idx == 4'd0) running_maximum <= rd_val;
        else if (f32rmr_pkg::ge32(rd_val, running_maximum)) running_maximum <= rd_val;
      end
      if (cmd.emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // lanes: seed on the first value, keep the larger in block positions
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      if (cnt_ext == 32'd0) begin
        for (int j = 0; j < f32rmr_pkg::LANES; j++) lane_values[j] <= sample_bits;
      end else if (!nan_seen && !x_nan && cnt_ext <= blocks &&
                   f32rmr_pkg::ge32(sample_bits, rd_val)) begin
        lane_values[lane_sel] <= sample_bits;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      maximum_bits  <= f32rmr_pkg::widen(res);
      result_is_nan <= nan_seen;
    end
  end

endmodule

@@ design/float32_row_max_reduction.sv @@
// Row maximum over a stream of binary32 values. Each run of
// row_columns * row_repetitions requests reduces to one binary64 result
// (a register value of 0 counts as 1). Values enter one per cycle while
// in_ready is high. In a run of more than 16 values, the last value of the
// block part starts a lane merge, stepped through the lanes in their fixed
// tie order by the controller, during which in_ready is low. A NaN seen
// before the end of the block part drops the merge. Each run end passes
// through an emit state that widens the result into the output register,
// and holds there while the previous result is still untaken; the next
// run's values are taken while that result waits.
module float32_row_max_reduction #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] sample_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] maximum_bits,
  output logic        result_is_nan,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  f32rmr_pkg::cmd_t cmd;
  f32rmr_pkg::sts_t sts;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  f32rmr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  f32rmr_dpath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dpath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .sample_bits   (sample_bits),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .maximum_bits  (maximum_bits),
    .result_is_nan (result_is_nan)
  );

  // a merge request stalls input on the next cycle
  a_merge_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && sts.merge_go) |=> !in_ready)
    else $error("input taken during lane merge");

  // a run end holds input in the emit state
  a_end_stalls: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && sts.ends && !sts.merge_go) |=> !in_ready)
    else $error("input taken while result pending");

  // never overwrite an untaken result
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result overwritten");

endmodule
